// File: rtl/kar_pkg.sv
// ----------------------------------------------------------------------------
// kar_pkg: shared types and constants for the key auto-repeat engine
// Holds the fixed field widths, the timing thresholds of the repeat curve and
// the reciprocal used to divide elapsed time by one hundred.
// ----------------------------------------------------------------------------
`default_nettype none

package kar_pkg;

  localparam int unsigned KEY_W = 8;
  localparam int unsigned TIME_W = 32;

  // A sampled bitmap with every key down marks an invalid poll.
  localparam logic [KEY_W-1:0] INVALID_KEYS = 8'hFF;

  // Repeat curve: slow repeat after one second, fast repeat after five.
  localparam logic [TIME_W-1:0] SLOW_START_MS = 32'd1000;
  localparam logic [TIME_W-1:0] FAST_START_MS = 32'd5000;
  localparam logic [7:0] FAST_BASE_COUNT = 8'd25;

  // floor(x / 100) == (x * DIV100_MAGIC) >> DIV100_SHIFT for every 32-bit x.
  localparam logic [TIME_W-1:0] DIV100_MAGIC = 32'h51EB851F;
  localparam int unsigned DIV100_SHIFT = 37;

  // Pipeline control shared by the lanes and the merging stage.
  typedef struct packed {
    logic accept;   // an input item is taken into stage one this cycle
    logic advance;  // stage one moves into the result register this cycle
  } kar_ctrl_t;

endpackage : kar_pkg

`default_nettype wire

// File: rtl/kar_lane.sv
// ----------------------------------------------------------------------------
// kar_lane: one key's press and repeat logic
// Stage one tracks the held flag and press time and forms the elapsed time;
// stage two divides it, compares against the last count and raises the event.
// ----------------------------------------------------------------------------
`default_nettype none

module kar_lane
  import kar_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire kar_ctrl_t         ctrl,
  input  wire logic              poll_invalid,
  input  wire logic              key_down,
  input  wire logic              key_sel,
  input  wire logic              key_rep,
  input  wire logic [TIME_W-1:0] now_ms,
  output logic                   event_bit
);

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_PRESS,
    ACT_REPEAT,
    ACT_RELEASE
  } act_t;

  logic              held;
  logic [TIME_W-1:0] press_time;
  logic [7:0]        repeat_count;

  // Stage one registers.
  act_t              s1_act;
  logic              s1_over_slow;
  logic              s1_over_fast;
  logic [TIME_W-1:0] s1_delta;

  logic [TIME_W-1:0] elapsed;
  logic              over_slow;
  logic              over_fast;
  logic [TIME_W-1:0] delta;
  act_t              act;

  always_comb begin
    elapsed   = now_ms - press_time;
    over_slow = elapsed > SLOW_START_MS;
    over_fast = elapsed > FAST_START_MS;
    delta     = over_fast ? (elapsed - FAST_START_MS) : (elapsed - SLOW_START_MS);
    act       = ACT_NONE;
    if (!poll_invalid && key_sel) begin
      if (key_down) begin
        if (!held) begin
          act = ACT_PRESS;
        end else if (key_rep) begin
          act = ACT_REPEAT;
        end
      end else begin
        act = ACT_RELEASE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held       <= 1'b0;
      press_time <= '0;
      s1_act     <= ACT_NONE;
    end else if (ctrl.accept) begin
      s1_act       <= act;
      s1_over_slow <= over_slow;
      s1_over_fast <= over_fast;
      s1_delta     <= delta;
      case (act)
        ACT_PRESS: begin
          held       <= 1'b1;
          press_time <= now_ms;
        end
        ACT_RELEASE: begin
          held       <= 1'b0;
          press_time <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Stage two: one reciprocal multiply gives the quotient by one hundred.
  logic [2*TIME_W-1:0] product;
  logic [TIME_W-1:0]   quot;
  logic [7:0]          count;
  logic                changed;

  always_comb begin
    product = s1_delta * DIV100_MAGIC;
    quot    = TIME_W'(product >> DIV100_SHIFT);
    if (s1_over_fast) begin
      count = FAST_BASE_COUNT + quot[7:0];
    end else if (s1_over_slow) begin
      count = quot[8:1];
    end else begin
      count = 8'd0;
    end
    changed   = count != repeat_count;
    event_bit = (s1_act == ACT_PRESS) || ((s1_act == ACT_REPEAT) && changed);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_count <= 8'd0;
    end else if (ctrl.advance) begin
      case (s1_act)
        ACT_REPEAT: begin
          if (changed) begin
            repeat_count <= count;
          end
        end
        ACT_RELEASE: repeat_count <= 8'd0;
        default: begin
        end
      endcase
    end
  end

endmodule : kar_lane

`default_nettype wire

// File: rtl/kar_merge.sv
// ----------------------------------------------------------------------------
// kar_merge: result register for the combined event bitmap
// Gathers the lane event bits into one item and holds it until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module kar_merge
  import kar_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire kar_ctrl_t        ctrl,
  input  wire logic [KEY_W-1:0] lane_events,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output logic [KEY_W-1:0]      event_mask
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.advance) begin
      out_valid  <= 1'b1;
      event_mask <= lane_events;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule : kar_merge

`default_nettype wire

// File: rtl/key_autorepeat_accelerating_top.sv
// Path: an accepted item enters stage one, then moves on into the result register as soon
// as that register is free, and its result can be taken from there.
// Throughput: one item per cycle. Stage one takes a new item in the same cycle that it
// hands its item on, so the input stalls only while a result waits and stage one is full.
// Reset: rst is synchronous and active high; all keys start released with
// a zero repeat count, and both pipeline stages start empty.
// ----------------------------------------------------------------------------
// key_autorepeat_accelerating_top: eight-key press and auto-repeat engine
// Each poll item carries a key bitmap, a timestamp, an examine mask and a
// repeat-mode mask; the result item is the bitmap of keys that raised events.
// ----------------------------------------------------------------------------
`default_nettype none

module key_autorepeat_accelerating_top
  import kar_pkg::*;
#(
  parameter int unsigned NUM_KEYS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [KEY_W-1:0]  key_state,
  input  wire logic [TIME_W-1:0] now_ms,
  input  wire logic [KEY_W-1:0]  key_mask,
  input  wire logic [KEY_W-1:0]  repeat_mode,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [KEY_W-1:0]       event_mask
);

  // Stage one holds one poll between its state update and its event compare.
  // Held flags and press times change when an item enters stage one, repeat
  // counts change when it leaves, so each kind of state sees items in order.
  logic      s1_valid;
  kar_ctrl_t ctrl;
  logic      poll_invalid;
  logic [KEY_W-1:0] lane_events;

  assign poll_invalid = key_state == INVALID_KEYS;

  always_comb begin
    ctrl.advance = s1_valid && (!out_valid || out_ready);
    in_ready     = !s1_valid || ctrl.advance;
    ctrl.accept  = in_valid && in_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ctrl.accept) begin
      s1_valid <= 1'b1;
    end else if (ctrl.advance) begin
      s1_valid <= 1'b0;
    end
  end

  // One lane per implemented key; keys beyond NUM_KEYS never raise events.
  for (genvar k = 0; k < KEY_W; k++) begin : g_lane
    if (k < NUM_KEYS) begin : g_on
      kar_lane u_lane (
        .clk          (clk),
        .rst          (rst),
        .ctrl         (ctrl),
        .poll_invalid (poll_invalid),
        .key_down     (key_state[k]),
        .key_sel      (key_mask[k]),
        .key_rep      (repeat_mode[k]),
        .now_ms       (now_ms),
        .event_bit    (lane_events[k])
      );
    end else begin : g_off
      assign lane_events[k] = 1'b0;
    end
  end

  // The merging stage registers the combined bitmap as the result item.
  kar_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .lane_events (lane_events),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .event_mask  (event_mask)
  );

endmodule : key_autorepeat_accelerating_top

`default_nettype wire

// File: dv/kar_checker.sv
// ----------------------------------------------------------------------------
// kar_checker: event predictor and scoreboard for the key auto-repeat engine
// Watches both channels, keeps its own per-key press state, predicts the
// event bitmap of every accepted poll item and compares it with the results.
// ----------------------------------------------------------------------------
`default_nettype none

module kar_checker
  import kar_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire logic [KEY_W-1:0]  key_state,
  input  wire logic [TIME_W-1:0] now_ms,
  input  wire logic [KEY_W-1:0]  key_mask,
  input  wire logic [KEY_W-1:0]  repeat_mode,
  input  wire logic              out_valid,
  input  wire logic              out_ready,
  input  wire logic [KEY_W-1:0]  event_mask,
  output int                     mismatches,
  output int                     outstanding
);

  localparam int unsigned KEYS = 8;

  logic              key_down [KEYS];
  logic [TIME_W-1:0] down_since [KEYS];
  logic [7:0]        last_level [KEYS];

  logic [KEY_W-1:0]  expected_events_q [$];
  int                results_seen;

  initial begin
    mismatches = 0;
    outstanding = 0;
    results_seen = 0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] kar_checker: %s", $realtime, what);
    mismatches++;
  endtask

  // Repeat level as a function of the time a key has been held.
  function automatic logic [7:0] repeat_level(input logic [TIME_W-1:0] held_ms);
    logic [TIME_W-1:0] lvl;
    lvl = '0;
    if (held_ms > FAST_START_MS) begin
      lvl = TIME_W'(FAST_BASE_COUNT) + (held_ms - FAST_START_MS) / 100;
    end else if (held_ms > SLOW_START_MS) begin
      lvl = (held_ms - SLOW_START_MS) / 200;
    end
    return lvl[7:0];
  endfunction

  // Updates the key state for one poll and returns the keys that fired.
  task automatic apply_poll(input logic [KEY_W-1:0] keys, input logic [TIME_W-1:0] stamp,
                            input logic [KEY_W-1:0] examine, input logic [KEY_W-1:0] repeating,
                            output logic [KEY_W-1:0] fired);
    logic [7:0] lvl;
    fired = '0;
    if (keys != INVALID_KEYS) begin
      for (int k = 0; k < KEYS; k++) begin
        if (examine[k]) begin
          if (keys[k]) begin
            if (!key_down[k]) begin
              key_down[k] = 1'b1;
              down_since[k] = stamp;
              fired[k] = 1'b1;
            end else if (repeating[k]) begin
              lvl = repeat_level(stamp - down_since[k]);
              if (lvl != last_level[k]) begin
                last_level[k] = lvl;
                fired[k] = 1'b1;
              end
            end
          end else begin
            key_down[k] = 1'b0;
            down_since[k] = '0;
            last_level[k] = '0;
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin : monitor
    logic [KEY_W-1:0] predicted;
    logic [KEY_W-1:0] wanted;
    if (rst) begin
      for (int k = 0; k < KEYS; k++) begin
        key_down[k] = 1'b0;
        down_since[k] = '0;
        last_level[k] = '0;
      end
      expected_events_q.delete();
      outstanding <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_events_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no poll waiting, event_mask %02h",
                                    results_seen, event_mask));
        end else begin
          wanted = expected_events_q.pop_front();
          if (event_mask !== wanted) begin
            report_mismatch($sformatf("result %0d: event_mask %02h, expected %02h",
                                      results_seen, event_mask, wanted));
          end
        end
        results_seen++;
      end
      if (in_valid && in_ready) begin
        apply_poll(key_state, now_ms, key_mask, repeat_mode, predicted);
        expected_events_q.push_back(predicted);
      end
      outstanding <= expected_events_q.size();
    end
  end

endmodule : kar_checker

`default_nettype wire

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the key auto-repeat engine
// Sends a directed set of polls covering the repeat curve, invalid samples,
// unexamined keys and timer wrap, then about 1800 random polls that model
// realistic typing with long holds. A side checker predicts every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import kar_pkg::*;

  // The watchdog limit is far above the slowest legal run: every item may
  // wait out a sender gap and a receiver stall, and one long hold-off
  // comes on top of that.
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_POLLS = 1800;
  // A result is taken only after its poll has passed stage one and the
  // result register; the drain allows a margin.
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_OFF_AFTER = 700;
  localparam int HOLD_OFF_CYCLES = 400;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [KEY_W-1:0]  key_state;
  logic [TIME_W-1:0] now_ms;
  logic [KEY_W-1:0]  key_mask;
  logic [KEY_W-1:0]  repeat_mode;
  logic              out_valid;
  logic              out_ready;
  logic [KEY_W-1:0]  event_mask;

  int mismatches;
  int outstanding;
  int polls_sent;
  int cycle_count;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  key_autorepeat_accelerating_top #(
    .NUM_KEYS(8)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .key_state(key_state),
    .now_ms(now_ms),
    .key_mask(key_mask),
    .repeat_mode(repeat_mode),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .event_mask(event_mask)
  );

  // The checker sees exactly what the block sees and keeps the score.
  kar_checker scoreboard (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .key_state(key_state),
    .now_ms(now_ms),
    .key_mask(key_mask),
    .repeat_mode(repeat_mode),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .event_mask(event_mask),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  // Offers one poll item and returns at the edge where it is taken. Valid is
  // left high so that a following item can go out back to back; the caller
  // lowers it when it opens a gap and after the last item.
  task automatic send_poll(input logic [KEY_W-1:0] keys, input logic [TIME_W-1:0] stamp,
                           input logic [KEY_W-1:0] examine, input logic [KEY_W-1:0] repeating);
    in_valid <= 1'b1;
    key_state <= keys;
    now_ms <= stamp;
    key_mask <= examine;
    repeat_mode <= repeating;
    do @(posedge clk); while (!in_ready);
    polls_sent++;
  endtask

  // Directed polls. Key 0 is walked along the repeat curve from a press at
  // time zero: no event at exactly one second, the first slow step, the jump
  // to the fast section just past five seconds, and the point where the
  // count wraps past 255 back to zero.
  task automatic run_directed();
    send_poll(8'h00, 32'd0, 8'hFF, 8'hFF);
    send_poll(8'h01, 32'd0, 8'hFF, 8'hFF);
    send_poll(8'h01, 32'd1000, 8'hFF, 8'hFF);
    send_poll(8'h01, 32'd1200, 8'hFF, 8'hFF);
    send_poll(8'h01, 32'd1399, 8'hFF, 8'hFF);
    send_poll(8'h01, 32'd5000, 8'hFF, 8'hFF);
    send_poll(8'h01, 32'd5001, 8'hFF, 8'hFF);
    send_poll(8'h01, 32'd5100, 8'hFF, 8'hFF);
    send_poll(8'h01, 32'd28100, 8'hFF, 8'hFF);
    // An invalid sample must neither fire nor release anything.
    send_poll(INVALID_KEYS, 32'd40000, 8'hFF, 8'hFF);
    // Key 0 is released but not examined, so it stays down; the others press.
    send_poll(8'hFE, 32'd40000, 8'hFE, 8'h00);
    // Held keys without repeat mode stay quiet; key 0 now releases.
    send_poll(8'hFE, 32'd50000, 8'hFF, 8'h00);
    send_poll(8'hFE, 32'd50000, 8'hFF, 8'hFF);
    send_poll(8'h00, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    // A press just before the timer wraps, then a repeat just after it.
    send_poll(8'h80, 32'hFFFF_FF00, 8'h80, 8'h80);
    send_poll(8'h80, 32'h0000_0400, 8'h80, 8'h80);
    send_poll(8'h7F, 32'hFFFF_FFFF, 8'h55, 8'hAA);
    send_poll(8'hAA, 32'h8000_0000, 8'hFF, 8'hFF);
    send_poll(8'hAA, 32'h8000_1771, 8'hFF, 8'h0F);
    send_poll(8'h00, 32'h8000_2000, 8'h00, 8'hFF);
    send_poll(8'h00, 32'h8000_2000, 8'hFF, 8'h00);
  endtask

  // Stimulus and verdict.
  initial begin : sender
    logic [KEY_W-1:0]  keys_down;
    logic [KEY_W-1:0]  repeating;
    logic [TIME_W-1:0] clock_ms;
    logic [KEY_W-1:0]  examine;
    logic [KEY_W-1:0]  sample;
    int                burst_left;
    int                gap;
    int                pick;

    rst <= 1'b1;
    in_valid <= 1'b0;
    key_state <= '0;
    now_ms <= '0;
    key_mask <= '0;
    repeat_mode <= '0;
    polls_sent = 0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    run_directed();

    // Random typing: keys change rarely, so they are held for many polls
    // and walk far along the repeat curve. The clock mostly creeps forward,
    // sometimes leaps by seconds, and now and then jumps anywhere. A few
    // polls are invalid samples or completely random noise.
    keys_down = '0;
    repeating = 8'($urandom);
    clock_ms = $urandom;
    burst_left = 0;
    for (int n = 0; n < RANDOM_POLLS; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;

      pick = $urandom_range(0, 63);
      if (pick == 0) begin
        clock_ms = $urandom;
      end else if (pick < 8) begin
        clock_ms = clock_ms + $urandom_range(1000, 6000);
      end else begin
        clock_ms = clock_ms + $urandom_range(0, 250);
      end

      for (int k = 0; k < KEY_W; k++) begin
        if ($urandom_range(0, 47) == 0) begin
          keys_down[k] = ~keys_down[k];
        end
      end
      if (keys_down == INVALID_KEYS) begin
        keys_down[$urandom_range(0, KEY_W - 1)] = 1'b0;
      end
      if ($urandom_range(0, 99) == 0) begin
        repeating = 8'($urandom);
      end
      examine = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'hFF;
      sample = keys_down;

      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send_poll(INVALID_KEYS, clock_ms, examine, repeating);
      end else if (pick < 6) begin
        send_poll(8'($urandom), $urandom, 8'($urandom), 8'($urandom));
      end else begin
        send_poll(sample, clock_ms, examine, repeating);
      end
    end
    in_valid <= 1'b0;

    // Let every predicted result come back, then allow a short drain so
    // that any stray extra result is still seen by the checker.
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Result side. The receiver runs segments of random length, each with its
  // own readiness pattern: always ready, coin flip, mostly stalled, or mostly
  // ready. Once, partway through the random polls, it holds off for a long
  // stretch so that the pipeline fills and the block must drop in_ready.
  initial begin : receiver
    int  seg_len;
    int  mode;
    bit  held_off;
    held_off = 1'b0;
    forever begin
      if (!held_off && polls_sent >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      seg_len = $urandom_range(1, 40);
      repeat (seg_len) begin
        case (mode)
          0: begin
            out_ready <= 1'b1;
          end
          1: begin
            out_ready <= 1'($urandom_range(0, 1));
          end
          2: begin
            out_ready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            out_ready <= ($urandom_range(0, 7) != 0);
          end
        endcase
        @(posedge clk);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule : tb_top

`default_nettype wire

// File: key_autorepeat_accelerating_top.f
rtl/kar_pkg.sv
rtl/kar_lane.sv
rtl/kar_merge.sv
rtl/key_autorepeat_accelerating_top.sv
dv/kar_checker.sv
dv/tb_top.sv
